// File: hw/rtl/dfr_pkg.sv
// Shared types and constants for the delimited frame receiver.
// Holds the beat structs, state enum, register map and controller/datapath links.
// No dependencies.
`timescale 1ns / 1ps

package dfr_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int STORE_SLOTS      = 32;

    localparam logic [7:0] START_BYTE_RST      = 8'd2;
    localparam logic [7:0] END_BYTE_RST        = 8'd3;
    localparam logic [7:0] TIMEOUT_TICKS_RST   = 8'd50;
    localparam logic [4:0] LENGTH_POSITION_RST = 5'd5;
    localparam logic [5:0] LENGTH_OVERHEAD_RST = 6'd8;

    localparam int CFG_INDEX_W = 3;

    typedef enum logic [0:0] {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } opcode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_BYTE      = 3'd0,
        CFG_END_BYTE        = 3'd1,
        CFG_TIMEOUT_TICKS   = 3'd2,
        CFG_LENGTH_POSITION = 3'd3,
        CFG_LENGTH_OVERHEAD = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK_RD,
        ST_CHECK,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic [0:0] opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [4:0] byte_index;
        logic       last_byte;
    } out_item_t;

    typedef struct packed {
        logic accept;
        logic chk_rd;
        logic emit_start;
        logic emit_rd;
        logic emit_load;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic end_hit;
        logic frame_ok;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: hw/rtl/delimited_frame_receiver_core.sv
// Top level of the delimited frame receiver: controller plus datapath.
// Depends on dfr_pkg, dfr_ctrl and dfr_datapath.
//
//  channel  ports                                   beat
//  input    s_valid s_ready s_data                  opcode, rx_byte
//  result   m_valid m_ready m_data                  frame_byte, byte_index, last_byte
//  config   cfg_valid cfg_ready cfg_index cfg_data  register write
//
// A tick or an ordinary byte is accepted in the idle state; an end byte is stored, then
// the length byte is read through the single frame store read port, then compared.
// A completed frame is emitted byte by byte through that same read port and the output register.
// Reset is synchronous, active low; the store needs no clearing pass.
// m_ready low holds the output register; the input stalls during the length
// check and during emission.
`timescale 1ns / 1ps

module delimited_frame_receiver_core #(
    parameter int BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  dfr_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output dfr_pkg::out_item_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);

    dfr_pkg::dp_cmd_t    cmd;
    dfr_pkg::dp_status_t status;

    dfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dfr_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// File: hw/rtl/dfr_ctrl.sv
// Controller for the delimited frame receiver: sequences store, length check and emission.
// Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  dfr_pkg::dp_status_t status,
    output dfr_pkg::dp_cmd_t    cmd
);

    dfr_pkg::state_t state_reg;
    dfr_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dfr_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dfr_pkg::ST_IDLE: begin
                if (s_valid && status.end_hit) begin
                    state_next = dfr_pkg::ST_CHECK_RD;
                end
            end
            dfr_pkg::ST_CHECK_RD: begin
                state_next = dfr_pkg::ST_CHECK;
            end
            dfr_pkg::ST_CHECK: begin
                state_next = status.frame_ok ? dfr_pkg::ST_EMIT_RD : dfr_pkg::ST_IDLE;
            end
            dfr_pkg::ST_EMIT_RD: begin
                state_next = dfr_pkg::ST_EMIT_LD;
            end
            dfr_pkg::ST_EMIT_LD: begin
                if (status.out_free) begin
                    state_next = status.emit_last ? dfr_pkg::ST_IDLE : dfr_pkg::ST_EMIT_RD;
                end
            end
            default: begin
                state_next = dfr_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        case (state_reg)
            dfr_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            dfr_pkg::ST_CHECK_RD: begin
                cmd.chk_rd = 1'b1;
            end
            dfr_pkg::ST_CHECK: begin
                cmd.emit_start = 1'b1;
            end
            dfr_pkg::ST_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
            end
            dfr_pkg::ST_EMIT_LD: begin
                cmd.emit_load = status.out_free;
                cmd.finish    = status.out_free && status.emit_last;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/dfr_datapath.sv
// Datapath for the delimited frame receiver: config registers, counters,
// frame store and output register. Depends on dfr_pkg.
`timescale 1ns / 1ps

module dfr_datapath #(
    parameter int BUFFER_DEPTH = dfr_pkg::BUFFER_DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dfr_pkg::in_item_t                   s_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dfr_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [7:0]                          cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output dfr_pkg::out_item_t                  m_data,
    input  dfr_pkg::dp_cmd_t                    cmd,
    output dfr_pkg::dp_status_t                 status
);

    localparam int CAP   = (BUFFER_DEPTH < dfr_pkg::STORE_SLOTS) ?
                           BUFFER_DEPTH : dfr_pkg::STORE_SLOTS;
    localparam int IDX_W = $clog2(CAP);
    localparam int CNT_W = $clog2(CAP + 1);

    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic [7:0] timeout_ticks_reg;
    logic [4:0] length_position_reg;
    logic [5:0] length_overhead_reg;

    logic             receiving_reg, receiving_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       tick_reg, tick_next;
    logic [IDX_W-1:0] emit_idx_reg;
    logic [7:0]       rd_data_reg;
    logic [7:0]       store_mem [CAP];

    logic               out_valid_reg;
    dfr_pkg::out_item_t out_data_reg;

    logic             is_byte;
    logic             take_byte;
    logic             overflow;
    logic             store_wr;
    logic [7:0]       tick_inc;
    logic [IDX_W-1:0] rd_addr;
    logic [5:0]       count_ext;
    logic [5:0]       len_expect;
    logic [7:0]       len_byte;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_byte_reg      <= dfr_pkg::START_BYTE_RST;
            end_byte_reg        <= dfr_pkg::END_BYTE_RST;
            timeout_ticks_reg   <= dfr_pkg::TIMEOUT_TICKS_RST;
            length_position_reg <= dfr_pkg::LENGTH_POSITION_RST;
            length_overhead_reg <= dfr_pkg::LENGTH_OVERHEAD_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                dfr_pkg::CFG_START_BYTE:      start_byte_reg      <= cfg_data;
                dfr_pkg::CFG_END_BYTE:        end_byte_reg        <= cfg_data;
                dfr_pkg::CFG_TIMEOUT_TICKS:   timeout_ticks_reg   <= cfg_data;
                dfr_pkg::CFG_LENGTH_POSITION: length_position_reg <= cfg_data[4:0];
                dfr_pkg::CFG_LENGTH_OVERHEAD: length_overhead_reg <= cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    assign is_byte   = (s_data.opcode == dfr_pkg::OP_BYTE);
    assign take_byte = is_byte && (receiving_reg || (s_data.rx_byte == start_byte_reg));
    assign overflow  = (count_reg >= CNT_W'(CAP));
    assign store_wr  = cmd.accept && take_byte && !overflow;
    assign tick_inc  = tick_reg + 8'd1;

    always_comb begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        tick_next      = tick_reg;
        if (cmd.finish) begin
            receiving_next = 1'b0;
            count_next     = '0;
            tick_next      = '0;
        end else if (cmd.accept) begin
            if (!is_byte) begin
                if (tick_reg != 8'd0) begin
                    tick_next = tick_inc;
                    if (tick_inc > timeout_ticks_reg) begin
                        receiving_next = 1'b0;
                        count_next     = '0;
                        tick_next      = '0;
                    end
                end
            end else if (take_byte) begin
                if (overflow) begin
                    receiving_next = 1'b0;
                    count_next     = '0;
                    tick_next      = '0;
                end else begin
                    receiving_next = 1'b1;
                    count_next     = count_reg + CNT_W'(1);
                    if (!receiving_reg) begin
                        tick_next = 8'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            tick_reg      <= '0;
        end else begin
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
            tick_reg      <= tick_next;
        end
    end

    assign rd_addr = cmd.chk_rd ? length_position_reg[IDX_W-1:0] : emit_idx_reg;

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[count_reg[IDX_W-1:0]] <= s_data.rx_byte;
        end
        if (cmd.chk_rd || cmd.emit_rd) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_start) begin
            emit_idx_reg <= '0;
        end else if (cmd.emit_load) begin
            emit_idx_reg <= emit_idx_reg + IDX_W'(1);
        end
    end

    // length byte not yet received reads as zero
    assign count_ext  = 6'(count_reg);
    assign len_expect = count_ext - length_overhead_reg;
    assign len_byte   = ({1'b0, length_position_reg} < count_ext) ? rd_data_reg : 8'd0;

    assign status.end_hit   = take_byte && !overflow && (s_data.rx_byte == end_byte_reg);
    assign status.frame_ok  = (count_ext >= length_overhead_reg) &&
                              (len_byte == {2'b00, len_expect});
    assign status.emit_last = ({1'b0, emit_idx_reg} == (count_reg - CNT_W'(1)));
    assign status.out_free  = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_data_reg.frame_byte <= rd_data_reg;
            out_data_reg.byte_index <= 5'(emit_idx_reg);
            out_data_reg.last_byte  <= status.emit_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// File: hw/rtl/dfr_checker.sv
// Port-level checks for the delimited frame receiver, bound to the top level.
// Depends on dfr_pkg and delimited_frame_receiver_core.
`timescale 1ns / 1ps

module dfr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input dfr_pkg::out_item_t m_data
);

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_data.last_byte |=> !m_valid || m_data.byte_index == 5'd0)
        else $error("new frame does not start at index zero");

    a_index_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_byte |=>
            !m_valid || m_data.byte_index == $past(m_data.byte_index) + 5'd1)
        else $error("byte index skipped within frame");

endmodule

bind delimited_frame_receiver_core dfr_checker u_dfr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// File: tb/tb_top.sv
// Self-checking testbench for delimited_frame_receiver_core: a scoreboard class predicts
// every frame byte from the accepted beats; tasks drive input and config, an always block m_ready.
// Depends on dfr_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int DEPTH        = dfr_pkg::BUFFER_DEPTH_DEF;
    localparam int LIMIT_CYCLES = 400000;

    typedef enum int {
        FR_GOOD,
        FR_BAD_LEN,
        FR_OVERFLOW,
        FR_TIMEOUT,
        FR_NOISE
    } frame_kind_t;

    class frame_scoreboard;
        logic [7:0]         start_b;
        logic [7:0]         end_b;
        logic [7:0]         tmo_ticks;
        logic [4:0]         len_pos;
        logic [5:0]         len_ovh;
        bit                 rx_active;
        logic [5:0]         count;
        logic [7:0]         tmo_count;
        logic [7:0]         store [dfr_pkg::STORE_SLOTS];
        dfr_pkg::out_item_t frames_due [$];
        int                 capacity;
        int                 errors;
        int                 checked;
        int                 frames_done;

        function new(int depth);
            capacity    = (depth < dfr_pkg::STORE_SLOTS) ? depth : dfr_pkg::STORE_SLOTS;
            start_b     = dfr_pkg::START_BYTE_RST;
            end_b       = dfr_pkg::END_BYTE_RST;
            tmo_ticks   = dfr_pkg::TIMEOUT_TICKS_RST;
            len_pos     = dfr_pkg::LENGTH_POSITION_RST;
            len_ovh     = dfr_pkg::LENGTH_OVERHEAD_RST;
            errors      = 0;
            checked     = 0;
            frames_done = 0;
            drop_frame();
        endfunction

        function void drop_frame();
            foreach (store[k]) store[k] = 8'h00;
            count     = '0;
            tmo_count = '0;
            rx_active = 1'b0;
        endfunction

        function void set_reg(dfr_pkg::cfg_index_t idx, logic [7:0] v);
            case (idx)
                dfr_pkg::CFG_START_BYTE:      start_b   = v;
                dfr_pkg::CFG_END_BYTE:        end_b     = v;
                dfr_pkg::CFG_TIMEOUT_TICKS:   tmo_ticks = v;
                dfr_pkg::CFG_LENGTH_POSITION: len_pos   = v[4:0];
                dfr_pkg::CFG_LENGTH_OVERHEAD: len_ovh   = v[5:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        // An end byte must never make the block read a store entry not yet written
        // in this frame, so such a byte is swapped for a harmless one.
        function dfr_pkg::in_item_t sanitise(dfr_pkg::in_item_t it);
            int n;
            if (dfr_pkg::opcode_t'(it.opcode) == dfr_pkg::OP_TICK) return it;
            if (rx_active) n = count;
            else if (it.rx_byte == start_b) n = 0;
            else return it;
            if (n >= capacity) return it;
            if (it.rx_byte == end_b && int'(len_pos) >= n + 1) begin
                it.rx_byte = rx_active ? end_b + 8'd1 : start_b + 8'd1;
            end
            return it;
        endfunction

        function void note_input(dfr_pkg::in_item_t it);
            logic [7:0]         b;
            logic [7:0]         lenb;
            dfr_pkg::out_item_t r;
            b = it.rx_byte;
            if (dfr_pkg::opcode_t'(it.opcode) == dfr_pkg::OP_TICK) begin
                if (tmo_count != 8'd0) begin
                    tmo_count = tmo_count + 8'd1;
                    if (tmo_count > tmo_ticks) drop_frame();
                end
                return;
            end
            if (!rx_active) begin
                if (b != start_b) return;
                foreach (store[k]) store[k] = 8'h00;
                count     = '0;
                tmo_count = 8'd1;
                rx_active = 1'b1;
            end
            if (int'(count) >= capacity) begin
                drop_frame();
                return;
            end
            store[count] = b;
            count = count + 6'd1;
            if (b == end_b) begin
                lenb = (int'(len_pos) < capacity) ? store[len_pos] : 8'h00;
                if (count >= len_ovh && int'(lenb) == int'(count) - int'(len_ovh)) begin
                    for (int k = 0; k < int'(count); k++) begin
                        r.frame_byte = store[k];
                        r.byte_index = 5'(k);
                        r.last_byte  = (k == int'(count) - 1);
                        frames_due.push_back(r);
                    end
                    frames_done++;
                    drop_frame();
                end
            end
        endfunction

        function void check_result(dfr_pkg::out_item_t got);
            dfr_pkg::out_item_t want;
            if (frames_due.size() == 0) begin
                $error("unexpected result beat: frame_byte %0h byte_index %0d last_byte %0b",
                       got.frame_byte, got.byte_index, got.last_byte);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            checked++;
            if (got.frame_byte !== want.frame_byte) begin
                $error("frame_byte: expected %0h, got %0h", want.frame_byte, got.frame_byte);
                errors++;
            end
            if (got.byte_index !== want.byte_index) begin
                $error("byte_index: expected %0d, got %0d", want.byte_index, got.byte_index);
                errors++;
            end
            if (got.last_byte !== want.last_byte) begin
                $error("last_byte: expected %0b, got %0b", want.last_byte, got.last_byte);
                errors++;
            end
        endfunction
    endclass

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    dfr_pkg::in_item_t               s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    dfr_pkg::out_item_t              m_data;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [dfr_pkg::CFG_INDEX_W-1:0] cfg_index = dfr_pkg::CFG_START_BYTE;
    logic [7:0]                      cfg_data  = 8'h00;

    frame_scoreboard sb;
    int  accepted      = 0;
    int  settings_used = 0;
    int  idle_odds     = 4;
    int  stall_odds    = 4;
    int  stall_left    = 0;

    delimited_frame_receiver_core #(
        .BUFFER_DEPTH(DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_odds == 0) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, stall_odds) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    task automatic push_item(dfr_pkg::opcode_t op, logic [7:0] b);
        dfr_pkg::in_item_t it;
        int                gap;
        it.opcode  = op;
        it.rx_byte = b;
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        it = sb.sanitise(it);
        s_data  <= it;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(it);
        accepted++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(dfr_pkg::cfg_index_t idx, logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, v);
    endtask

    task automatic load_settings(logic [7:0] st, logic [7:0] en, logic [7:0] to,
                                 logic [4:0] lp, logic [5:0] ov);
        wait_drained();
        repeat (8) @(posedge aclk);
        write_reg(dfr_pkg::CFG_START_BYTE, st);
        write_reg(dfr_pkg::CFG_END_BYTE, en);
        write_reg(dfr_pkg::CFG_TIMEOUT_TICKS, to);
        write_reg(dfr_pkg::CFG_LENGTH_POSITION, {3'b000, lp});
        write_reg(dfr_pkg::CFG_LENGTH_OVERHEAD, {2'b00, ov});
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic send_frame(frame_kind_t kind);
        logic [7:0] fb [34];
        int         n;
        int         lo;
        int         budget;
        if (kind == FR_NOISE) begin
            repeat ($urandom_range(1, 4)) begin
                push_item(dfr_pkg::opcode_t'($urandom_range(0, 1)), 8'($urandom));
            end
            return;
        end
        lo = int'(sb.len_pos) + 1;
        if (int'(sb.len_ovh) > lo) lo = int'(sb.len_ovh);
        if (lo < 2) lo = 2;
        if (lo > 32) lo = 32;
        n = lo + $urandom_range(0, (32 - lo < 6) ? 32 - lo : 6);
        if (sb.len_pos == 0 && int'(sb.start_b) + int'(sb.len_ovh) >= 2 &&
            int'(sb.start_b) + int'(sb.len_ovh) <= 32) begin
            n = int'(sb.start_b) + int'(sb.len_ovh);
        end
        if (kind == FR_OVERFLOW) n = 33 + $urandom_range(0, 1);
        for (int k = 0; k < n; k++) begin
            fb[k] = 8'($urandom);
            if (fb[k] == sb.end_b) fb[k] = ~fb[k];
        end
        fb[0] = sb.start_b;
        if (kind != FR_OVERFLOW) begin
            if (sb.len_pos != 0) fb[sb.len_pos] = 8'(n - int'(sb.len_ovh));
            if (kind == FR_BAD_LEN) fb[sb.len_pos] = fb[sb.len_pos] ^ 8'h01;
            fb[n-1] = sb.end_b;
        end
        budget = int'(sb.tmo_ticks) - 1;
        for (int k = 0; k < n; k++) begin
            push_item(dfr_pkg::OP_BYTE, fb[k]);
            if (k == 0 && kind == FR_TIMEOUT) begin
                repeat (int'(sb.tmo_ticks)) push_item(dfr_pkg::OP_TICK, 8'($urandom));
            end else if (kind != FR_TIMEOUT && budget > 0 && $urandom_range(0, 5) == 0) begin
                push_item(dfr_pkg::OP_TICK, 8'($urandom));
                budget--;
            end
        end
    endtask

    task automatic run_phase(int target, bit quiet);
        int          stop_at;
        int          pick;
        frame_kind_t kind;
        stop_at = accepted + target;
        while (accepted < stop_at) begin
            if (quiet) begin
                idle_odds  = 0;
                stall_odds = 0;
            end else begin
                idle_odds  = ($urandom_range(0, 3) == 0) ? 0 : 4;
                stall_odds = ($urandom_range(0, 3) == 0) ? 0 : 4;
            end
            pick = $urandom_range(0, 19);
            if (sb.rx_active && pick < 10) kind = (sb.tmo_ticks <= 20) ? FR_TIMEOUT : FR_OVERFLOW;
            else if (pick < 14) kind = FR_GOOD;
            else if (pick < 16) kind = FR_BAD_LEN;
            else if (pick < 17) kind = FR_OVERFLOW;
            else if (pick < 18) kind = (sb.tmo_ticks <= 20) ? FR_TIMEOUT : FR_BAD_LEN;
            else kind = FR_NOISE;
            send_frame(kind);
            if ($urandom_range(0, 7) == 0) wait_drained();
        end
    endtask

    initial begin
        sb = new(DEPTH);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset settings: idle tick and noise, then two frames with the usual corner bytes
        push_item(dfr_pkg::OP_TICK, 8'hFF);
        push_item(dfr_pkg::OP_BYTE, 8'h00);
        push_item(dfr_pkg::OP_BYTE, 8'hFF);
        push_item(dfr_pkg::OP_BYTE, 8'h02);
        push_item(dfr_pkg::OP_BYTE, 8'h02);
        push_item(dfr_pkg::OP_BYTE, 8'hFF);
        push_item(dfr_pkg::OP_BYTE, 8'h00);
        push_item(dfr_pkg::OP_BYTE, 8'h80);
        push_item(dfr_pkg::OP_BYTE, 8'h00);
        push_item(dfr_pkg::OP_TICK, 8'h00);
        push_item(dfr_pkg::OP_BYTE, 8'h03);
        push_item(dfr_pkg::OP_BYTE, 8'h03);
        push_item(dfr_pkg::OP_BYTE, 8'h02);
        push_item(dfr_pkg::OP_BYTE, 8'h11);
        push_item(dfr_pkg::OP_BYTE, 8'h22);
        push_item(dfr_pkg::OP_BYTE, 8'h33);
        push_item(dfr_pkg::OP_BYTE, 8'h44);
        push_item(dfr_pkg::OP_BYTE, 8'h01);
        push_item(dfr_pkg::OP_BYTE, 8'h55);
        push_item(dfr_pkg::OP_BYTE, 8'h66);
        push_item(dfr_pkg::OP_BYTE, 8'h03);
        wait_drained();
        run_phase(10, 1'b0);

        load_settings(8'h00, 8'hFF, 8'd1, 5'd0, 6'd32);
        run_phase(5, 1'b0);
        load_settings(8'hFF, 8'h00, 8'd254, 5'd31, 6'd32);
        run_phase(5, 1'b0);
        load_settings(8'h04, 8'hFF, 8'd200, 5'd0, 6'd0);
        run_phase(10, 1'b0);
        repeat (2) begin
            load_settings(8'($urandom), 8'($urandom),
                          ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 12))
                                                      : 8'($urandom_range(13, 254)),
                          5'($urandom_range(0, 10)), 6'($urandom_range(0, 16)));
            run_phase(12, 1'b0);
        end
        load_settings(8'($urandom), 8'($urandom), 8'($urandom_range(2, 12)),
                      5'($urandom_range(0, 10)), 6'($urandom_range(0, 16)));
        run_phase(15, 1'b1);

        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Run fed %0d input beats under %0d register settings plus reset values.",
                 accepted, settings_used);
        $display("%0d frames completed, %0d result beats checked.", sb.frames_done, sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/dfr_pkg.sv
hw/rtl/dfr_ctrl.sv
hw/rtl/dfr_datapath.sv
hw/rtl/delimited_frame_receiver_core.sv
hw/rtl/dfr_checker.sv
tb/tb_top.sv
